// ===== design/assert_macros.svh =====
// assertion helpers for the rtl files, included by the serialiser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define P2R_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define P2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/p2rgba_pkg.sv =====
// ----------------------------------------------------------------------------
// p2rgba_pkg
// shared types, codes and helpers of the planar to rgba pixel resolver
// ----------------------------------------------------------------------------
`default_nettype none

package p2rgba_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  // color mode register codes
  localparam logic [2:0] MODE_BITMAP  = 3'd0;
  localparam logic [2:0] MODE_GRAY    = 3'd1;
  localparam logic [2:0] MODE_INDEXED = 3'd2;
  localparam logic [2:0] MODE_RGB     = 3'd3;
  localparam logic [2:0] MODE_CMYK    = 3'd4;

  // sample format register codes
  localparam logic [1:0] FMT_1  = 2'd0;
  localparam logic [1:0] FMT_8  = 2'd1;
  localparam logic [1:0] FMT_16 = 2'd2;
  localparam logic [1:0] FMT_32 = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_COLOR_MODE    = 2'd0;
  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd1;
  localparam logic [1:0] REG_CHANNELS_USED = 2'd2;

  localparam logic [2:0] CHANNELS_WITH_ALPHA = 3'd4;

  // full-scale alpha per sample width
  localparam logic [31:0] FULL_8  = 32'h0000_00ff;
  localparam logic [31:0] FULL_16 = 32'h0000_ffff;
  localparam logic [31:0] FULL_32 = 32'h3f80_0000;

  localparam logic [31:0] MASK_8  = 32'h0000_00ff;
  localparam logic [31:0] MASK_16 = 32'h0000_ffff;
  localparam logic [31:0] MASK_32 = 32'hffff_ffff;

  localparam logic [3:0] BITMAP_MAX = 4'd8;

  // one output item as loaded into the serialiser
  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
    logic [7:0]  bits;   // remaining bitmap bits, msb next after the current word
    logic [3:0]  count;  // words this item produces, 1 to 8
  } pix_t;

  // exact x/255 for any product of two 8-bit values (x up to 255*255)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  // bitmap pixel value: set bit gives black
  function automatic logic [31:0] bit_level(input logic b);
    return b ? 32'd0 : FULL_8;
  endfunction

endpackage

`default_nettype wire

// ===== design/p2rgba_palette.sv =====
// ----------------------------------------------------------------------------
// p2rgba_palette
// palette memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module p2rgba_palette #(
  parameter int ENTRIES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  wire logic [23:0]                wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic      [23:0]                rd_data
);

  logic [23:0] mem [ENTRIES];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/p2rgba_serializer.sv =====
// ----------------------------------------------------------------------------
// p2rgba_serializer
// output register, expands a bitmap byte into up to eight words
// ----------------------------------------------------------------------------
`default_nettype none

module p2rgba_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              ld_valid,
  input  wire p2rgba_pkg::pix_t  ld_pix,
  output logic                   ld_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [127:0]           out_data,
  output logic                   out_last
);

  import p2rgba_pkg::*;

  logic        valid_r, valid_nxt;
  logic [3:0]  remain_r, remain_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [31:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [31:0] alpha_r, alpha_nxt;
  logic        last_word;
  logic [31:0] lvl;

  assign last_word = (remain_r == 4'd1);
  assign ld_ready  = !valid_r || (out_ready && last_word);
  assign lvl       = bit_level(bits_r[7]);

  always_comb begin
    valid_nxt  = valid_r;
    remain_nxt = remain_r;
    bits_nxt   = bits_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    alpha_nxt  = alpha_r;
    if (ld_valid && ld_ready) begin
      valid_nxt  = 1'b1;
      remain_nxt = ld_pix.count;
      bits_nxt   = ld_pix.bits;
      red_nxt    = ld_pix.red;
      green_nxt  = ld_pix.green;
      blue_nxt   = ld_pix.blue;
      alpha_nxt  = ld_pix.alpha;
    end else if (valid_r && out_ready) begin
      if (last_word) begin
        valid_nxt = 1'b0;
      end else begin
        // next bitmap pixel
        remain_nxt = remain_r - 4'd1;
        bits_nxt   = {bits_r[6:0], 1'b0};
        red_nxt    = lvl;
        green_nxt  = lvl;
        blue_nxt   = lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      remain_r <= 4'd0;
    end else begin
      valid_r  <= valid_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r  <= bits_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    alpha_r <= alpha_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = {alpha_r, blue_r, green_r, red_r};
  assign out_last  = last_word;

  `include "assert_macros.svh"

  `P2R_ASSERT_IMPLY(a_remain_range, clk, rst_n, valid_r, (remain_r != 4'd0) && (remain_r <= BITMAP_MAX), "word count out of range")
  `P2R_ASSERT_NEXT(a_run_continues, clk, rst_n, valid_r && out_ready && !last_word, valid_r, "bitmap run dropped")
  `P2R_ASSERT_NEXT(a_run_counts_down, clk, rst_n, valid_r && out_ready && !last_word, remain_r == $past(remain_r) - 4'd1, "bitmap count skipped")
  `P2R_ASSERT_IMPLY(a_no_load_mid_run, clk, rst_n, valid_r && !last_word, !ld_ready, "load taken during a bitmap run")

endmodule

`default_nettype wire

// ===== design/planar_to_rgba_pixel_resolver.sv =====
// an accepted pixel word is registered in stage one, then in the serialiser output register before it is sent
// throughput: one pixel word per cycle while the output is ready and no bitmap run is in progress;
//   a bitmap byte yields one word per pixel (up to 8), and stage one holds until the serialiser has sent them all
// palette writes produce no output; the palette memory is written on accept
// reset: synchronous active-low rst_n clears pipeline valids and loads color_mode 1,
//   sample_format 1, channels_used 3; palette contents stay undefined until written
// ----------------------------------------------------------------------------
// planar_to_rgba_pixel_resolver
// converts planar channel samples into interleaved rgba words per color mode
// ----------------------------------------------------------------------------
`default_nettype none

module planar_to_rgba_pixel_resolver #(
  parameter int PALETTE_ENTRIES = p2rgba_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration write port
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [2:0]   cfg_wdata,
  // input words
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // sample0[31:0] sample1[63:32] sample2[95:64] sample3[127:96] pixel_count[131:128]
  // palette_index[139:132] palette_red[147:140] palette_green[155:148]
  // palette_blue[163:156] zero pad[167:164]
  input  wire logic [167:0] in_tdata,
  // kind[0]
  input  wire logic         in_tuser,
  // output words
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // red[31:0] green[63:32] blue[95:64] alpha[127:96]
  output logic [127:0]      out_tdata,
  // last_pixel
  output logic              out_tlast
);

  import p2rgba_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  // what stage one holds
  typedef enum logic [1:0] {
    S1_DIRECT,
    S1_INDEXED,
    S1_CMYK
  } s1_kind_t;

  // ---- configuration registers ----
  logic [2:0] mode_r;
  logic [1:0] fmt_r;
  logic [2:0] chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GRAY;
      fmt_r  <= FMT_8;
      chan_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_MODE:    mode_r <= cfg_wdata;
        REG_SAMPLE_FORMAT: fmt_r  <= cfg_wdata[1:0];
        REG_CHANNELS_USED: chan_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- input field unpack ----
  logic [31:0] s0, s1, s2, s3;
  logic [3:0]  pcount;
  logic [7:0]  pidx, pred, pgreen, pblue;

  assign s0     = in_tdata[31:0];
  assign s1     = in_tdata[63:32];
  assign s2     = in_tdata[95:64];
  assign s3     = in_tdata[127:96];
  assign pcount = in_tdata[131:128];
  assign pidx   = in_tdata[139:132];
  assign pred   = in_tdata[147:140];
  assign pgreen = in_tdata[155:148];
  assign pblue  = in_tdata[163:156];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // ---- palette memory: written on accept of a palette word, read on accept of a pixel word ----
  logic        pal_we, pal_re;
  logic [23:0] pal_rd;

  assign pal_we = in_acc && in_tuser && (32'(pidx) < 32'(PALETTE_ENTRIES));
  assign pal_re = in_acc && !in_tuser;

  p2rgba_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_we),
    .wr_addr (pidx[IDX_W-1:0]),
    .wr_data ({pred, pgreen, pblue}),
    .rd_en   (pal_re),
    .rd_addr (s0[IDX_W-1:0]),
    .rd_data (pal_rd)
  );

  // ---- decode of an incoming pixel word ----
  logic        produce;
  s1_kind_t    kind_nxt;
  pix_t        pix_nxt;
  logic [31:0] mask, full;
  logic        fmt_ok;
  logic [3:0]  bm_n;
  logic        in_range_nxt;
  logic [15:0] prod_c_nxt, prod_m_nxt, prod_y_nxt;

  always_comb begin
    case (fmt_r)
      FMT_8:   begin mask = MASK_8;  full = FULL_8;  fmt_ok = 1'b1; end
      FMT_16:  begin mask = MASK_16; full = FULL_16; fmt_ok = 1'b1; end
      FMT_32:  begin mask = MASK_32; full = FULL_32; fmt_ok = 1'b1; end
      default: begin mask = '0;      full = '0;      fmt_ok = 1'b0; end
    endcase
  end

  // bitmap count saturates at eight
  assign bm_n = (pcount > BITMAP_MAX) ? BITMAP_MAX : pcount;

  // one 8x8 multiplier per cmyk channel, registered before the divide
  assign prod_c_nxt   = s0[7:0] * s3[7:0];
  assign prod_m_nxt   = s1[7:0] * s3[7:0];
  assign prod_y_nxt   = s2[7:0] * s3[7:0];
  assign in_range_nxt = (32'(s0[7:0]) < 32'(PALETTE_ENTRIES));

  always_comb begin
    produce  = 1'b0;
    kind_nxt = S1_DIRECT;
    pix_nxt  = '0;
    pix_nxt.count = 4'd1;
    case (mode_r)
      MODE_BITMAP: begin
        produce        = (bm_n != 4'd0);
        pix_nxt.red    = bit_level(s0[7]);
        pix_nxt.green  = bit_level(s0[7]);
        pix_nxt.blue   = bit_level(s0[7]);
        pix_nxt.alpha  = FULL_8;
        pix_nxt.bits   = {s0[6:0], 1'b0};
        pix_nxt.count  = bm_n;
      end
      MODE_GRAY: begin
        produce       = fmt_ok;
        pix_nxt.red   = s0 & mask;
        pix_nxt.green = s0 & mask;
        pix_nxt.blue  = s0 & mask;
        pix_nxt.alpha = full;
      end
      MODE_INDEXED: begin
        produce  = (fmt_r == FMT_8);
        kind_nxt = S1_INDEXED;
      end
      MODE_RGB: begin
        produce       = fmt_ok;
        pix_nxt.red   = s0 & mask;
        pix_nxt.green = s1 & mask;
        pix_nxt.blue  = s2 & mask;
        pix_nxt.alpha = (chan_r == CHANNELS_WITH_ALPHA) ? (s3 & mask) : full;
      end
      MODE_CMYK: begin
        produce  = (fmt_r == FMT_8);
        kind_nxt = S1_CMYK;
      end
      default: produce = 1'b0;
    endcase
  end

  // ---- stage one ----
  logic        s1_valid_r, s1_valid_nxt;
  s1_kind_t    s1_kind_r;
  pix_t        s1_pix_r;
  logic        s1_in_range_r;
  logic [15:0] s1_prod_c_r, s1_prod_m_r, s1_prod_y_r;
  logic        s1_adv;
  logic        ld_ready;

  // stage one moves on when empty or when the serialiser takes its word
  assign s1_adv    = !s1_valid_r || ld_ready;
  assign in_tready = s1_adv;

  // words that produce nothing (palette writes, unsupported modes or sample formats, zero bitmap counts) stop here
  assign s1_valid_nxt = s1_adv ? (in_acc && !in_tuser && produce) : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r     <= kind_nxt;
      s1_pix_r      <= pix_nxt;
      s1_in_range_r <= in_range_nxt;
      s1_prod_c_r   <= prod_c_nxt;
      s1_prod_m_r   <= prod_m_nxt;
      s1_prod_y_r   <= prod_y_nxt;
    end
  end

  // ---- stage one result: direct pixel, palette data or cmyk divide ----
  pix_t ld_pix;

  always_comb begin
    ld_pix = s1_pix_r;
    case (s1_kind_r)
      S1_INDEXED: begin
        ld_pix.red   = s1_in_range_r ? {24'd0, pal_rd[23:16]} : 32'd0;
        ld_pix.green = s1_in_range_r ? {24'd0, pal_rd[15:8]}  : 32'd0;
        ld_pix.blue  = s1_in_range_r ? {24'd0, pal_rd[7:0]}   : 32'd0;
        ld_pix.alpha = FULL_8;
      end
      S1_CMYK: begin
        ld_pix.red   = {24'd0, div255(s1_prod_c_r)};
        ld_pix.green = {24'd0, div255(s1_prod_m_r)};
        ld_pix.blue  = {24'd0, div255(s1_prod_y_r)};
        ld_pix.alpha = FULL_8;
      end
      default: ;
    endcase
  end

  // ---- output register and bitmap expansion ----
  p2rgba_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (s1_valid_r),
    .ld_pix    (ld_pix),
    .ld_ready  (ld_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
